// ----- sv/dfar_pkg.sv -----
`default_nettype none

package dfar_pkg;

	localparam int ACT_W  = 3;
	localparam int IDX_W  = 4;
	localparam int VAL_W  = 8;
	localparam int SYM_W  = 8;
	localparam int KIND_W = 2;
	localparam int VERD_W = 2;
	localparam int END_W  = 4;
	localparam int CFG_W  = 5;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD_NEXT = 3'd0,
		ACT_LOAD_KIND = 3'd1,
		ACT_LOAD_SYM  = 3'd2,
		ACT_FEED      = 3'd3,
		ACT_FINISH    = 3'd4
	} dfar_action_t;

	localparam logic [KIND_W-1:0] KIND_FINAL = 2'd2;

	localparam logic [VERD_W-1:0] VERDICT_ACCEPT       = 2'd0;
	localparam logic [VERD_W-1:0] VERDICT_NOT_ACCEPT   = 2'd1;
	localparam logic [VERD_W-1:0] VERDICT_UNRECOGNISED = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [IDX_W-1:0] state_index;
		logic [IDX_W-1:0] slot_index;
		logic [VAL_W-1:0] load_value;
		logic [SYM_W-1:0] symbol;
		logic             last_symbol;
	} dfar_in_t;

	typedef struct packed {
		logic [VERD_W-1:0] verdict;
		logic [END_W-1:0]  end_state;
	} dfar_out_t;

endpackage

`default_nettype wire

// ----- sv/dfar_ram.sv -----
`default_nettype none

module dfar_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/table_driven_dfa_recognizer.sv -----
// Channel   Direction  Handshake          Beat
// in        in         in_valid/in_stall  dfar_in_t: one load, feed or finish action
// out       out        out_valid/out_stall dfar_out_t: verdict and end state of one string
// cfg       in         cfg_valid/cfg_ready symbol_count, always ready
//
// One beat per cycle while not stalled. Verdicts pass the verdict stage and output buffer.
// The current state comes from the next-state RAM read port in the cycle after a matched
// character and is forwarded straight into the next lookup address.
// Reset clears state, reject flag, symbol count and output buffer; the tables keep contents.
// A two-entry output buffer takes results under back-pressure; in_stall rises when both
// entries are full.
`default_nettype none

module table_driven_dfa_recognizer #(
	parameter int MAX_STATES  = 16,
	parameter int MAX_SYMBOLS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  dfar_pkg::dfar_in_t          in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output dfar_pkg::dfar_out_t         out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [dfar_pkg::CFG_W-1:0]  cfg_data
);

	import dfar_pkg::*;

	localparam int SW    = $clog2(MAX_STATES);
	localparam int SLW   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int DEPTH = MAX_STATES * MAX_SYMBOLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int KD    = (MAX_STATES < 16) ? MAX_STATES : 16;
	localparam int KW    = $clog2(KD);
	localparam int EW    = (SW > END_W) ? SW : END_W;

	function automatic logic [255:0][SW-1:0] mod_tab_f();
		logic [255:0][SW-1:0] t;
		int r;
		r = 0;
		for (int i = 0; i < 256; i++) begin
			t[i] = SW'(r);
			r = (r + 1 == MAX_STATES) ? 0 : r + 1;
		end
		return t;
	endfunction

	localparam logic [255:0][SW-1:0] MOD_TAB = mod_tab_f();
	localparam logic [AW-1:0]        SYM_A   = AW'(MAX_SYMBOLS);

	logic [SYM_W-1:0]  alpha_q [MAX_SYMBOLS];
	logic [KIND_W-1:0] kind_q [KD];
	logic [CFG_W-1:0]  count_q;
	logic [SW-1:0]     cur_q;
	logic              pend_q;
	logic              rej_q;

	logic              fin_v_s1;
	logic              fin_rej_s1;
	logic              fin_fwd_s1;
	logic [SW-1:0]     fin_state_s1;

	logic              out_v_q;
	dfar_out_t         out_q;
	logic              skid_v_q;
	dfar_out_t         skid_q;

	logic              accept;
	logic              is_feed;
	logic              is_fin;
	logic              ends;
	logic              st_ok;
	logic              sl_ok;
	logic [MAX_SYMBOLS-1:0] hit;
	logic              match;
	logic [SLW-1:0]    slot;
	logic [SW-1:0]     rd_data;
	logic [SW-1:0]     s_eff;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [SW-1:0]     s_fin;
	logic [EW-1:0]     s_ext;
	dfar_out_t         res;
	logic              pop;
	logic              push;

	assign accept  = in_valid & ~in_stall;
	assign is_feed = accept && (in_data.action == ACT_FEED);
	assign is_fin  = accept && (in_data.action == ACT_FINISH);
	assign ends    = is_fin || (is_feed && in_data.last_symbol);
	assign st_ok   = 32'(in_data.state_index) < MAX_STATES;
	assign sl_ok   = 32'(in_data.slot_index) < MAX_SYMBOLS;

	always_comb begin
		for (int j = 0; j < MAX_SYMBOLS; j++) begin
			hit[j] = (alpha_q[j] == in_data.symbol) && (j < 32'(count_q));
		end
	end

	always_comb begin
		slot = '0;
		for (int j = MAX_SYMBOLS - 1; j >= 0; j--) begin
			if (hit[j]) begin
				slot = SLW'(j);
			end
		end
	end

	assign match = |hit;
	assign s_eff = pend_q ? rd_data : cur_q;

	assign ram_we    = accept && (in_data.action == ACT_LOAD_NEXT) && st_ok && sl_ok;
	assign ram_waddr = AW'(in_data.state_index) * SYM_A + AW'(in_data.slot_index);
	assign ram_re    = is_feed && !rej_q && match;
	assign ram_raddr = AW'(s_eff) * SYM_A + AW'(slot);

	dfar_ram #(
		.WIDTH (SW),
		.DEPTH (DEPTH)
	) u_next_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (MOD_TAB[in_data.load_value]),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk) begin
		if (accept && (in_data.action == ACT_LOAD_SYM) && sl_ok) begin
			alpha_q[SLW'(in_data.slot_index)] <= in_data.load_value;
		end
		if (accept && (in_data.action == ACT_LOAD_KIND) && st_ok) begin
			kind_q[in_data.state_index[KW-1:0]] <= in_data.load_value[KIND_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	// current state walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			pend_q <= 1'b0;
			rej_q  <= 1'b0;
		end else if (ends) begin
			cur_q  <= '0;
			pend_q <= 1'b0;
			rej_q  <= 1'b0;
		end else if (is_feed) begin
			if (!rej_q && match) begin
				pend_q <= 1'b1;
			end else begin
				cur_q  <= s_eff;
				pend_q <= 1'b0;
				rej_q  <= 1'b1;
			end
		end
	end

	// verdict stage
	assign s_fin = fin_fwd_s1 ? rd_data : fin_state_s1;
	assign s_ext = EW'(s_fin);

	always_comb begin
		res.end_state = s_ext[END_W-1:0];
		if (fin_rej_s1) begin
			res.verdict = VERDICT_UNRECOGNISED;
		end else if (kind_q[s_fin[KW-1:0]] == KIND_FINAL) begin
			res.verdict = VERDICT_ACCEPT;
		end else begin
			res.verdict = VERDICT_NOT_ACCEPT;
		end
	end

	assign pop  = out_v_q & ~out_stall;
	assign push = fin_v_s1 & (~skid_v_q | pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s1 <= 1'b0;
		end else if (!fin_v_s1 || push) begin
			fin_v_s1 <= ends;
		end
	end

	always_ff @(posedge clk) begin
		if (!fin_v_s1 || push) begin
			fin_rej_s1   <= rej_q || (is_feed && !match);
			fin_fwd_s1   <= (is_feed && !rej_q && match) ? 1'b1 : pend_q;
			fin_state_s1 <= cur_q;
		end
	end

	// two-entry output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= push;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_v_q) begin
			if (skid_v_q) begin
				out_q  <= skid_q;
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;
	assign in_stall  = skid_v_q;

endmodule

`default_nettype wire

// ----- sv/dfar_chk.sv -----
`default_nettype none

module dfar_chk (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_stall,
	input wire dfar_pkg::dfar_in_t         in_data,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire dfar_pkg::dfar_out_t        out_data,
	input wire logic                       cfg_valid,
	input wire logic                       cfg_ready
);

	import dfar_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat dropped or changed while stalled");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("output or stall active in reset");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	a_finish_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.action == ACT_FINISH) && !out_valid
			|-> ##2 out_valid)
		else $error("verdict missing two cycles after finish");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write refused");

endmodule

bind table_driven_dfa_recognizer dfar_chk u_dfar_chk (.*);

`default_nettype wire
